// File: design/gh_pkg.sv
// shared types and constants of the ghash authenticator
package gh_pkg;

    localparam int HALF_W      = 64;
    localparam int BLOCK_W     = 2 * HALF_W;
    localparam int BLOCK_BYTES = BLOCK_W / 8;
    localparam int COUNT_W     = 61;
    localparam int NBYTES_W    = 5;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;

    // item kinds
    localparam logic [1:0] KIND_AAD    = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // register select bit of paddr (registers at 0 and 8)
    localparam int REG_SEL_BIT = 3;
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [HALF_W-1:0]   data_high;
        logic [HALF_W-1:0]   data_low;
        logic [NBYTES_W-1:0] valid_bytes;
    } gh_in_t;

    typedef struct packed {
        logic [HALF_W-1:0] tag_high;
        logic [HALF_W-1:0] tag_low;
    } gh_out_t;

endpackage

// File: design/gh_gfmul.sv
// gf(2^128) multiplier in ghash bit order, purely combinational logic
module gh_gfmul
    import gh_pkg::*;
(
    input  logic [BLOCK_W-1:0] x_in,
    input  logic [BLOCK_W-1:0] h_in,
    output logic [BLOCK_W-1:0] z_out
);

    logic [BLOCK_W-1:0]   a;
    logic [BLOCK_W-1:0]   b;
    logic [2*BLOCK_W-2:0] prod;
    logic [BLOCK_W-2:0]   upper;
    logic [BLOCK_W+5:0]   fold1;
    logic [5:0]           spill;
    logic [BLOCK_W-1:0]   r;

    // ghash bit 0 is the msb of byte 0: reflect so index equals degree
    always_comb begin
        for (int i = 0; i < BLOCK_W; i++) begin
            a[i] = x_in[BLOCK_W-1-i];
            b[i] = h_in[BLOCK_W-1-i];
        end
    end

    // carry-less product, each coefficient an xor tree of partial products
    always_comb begin
        logic [BLOCK_W-1:0] terms;
        for (int k = 0; k < 2*BLOCK_W-1; k++) begin
            for (int i = 0; i < BLOCK_W; i++) begin
                if ((k - i >= 0) && (k - i < BLOCK_W)) begin
                    terms[i] = a[i] & b[k-i];
                end else begin
                    terms[i] = 1'b0;
                end
            end
            prod[k] = ^terms;
        end
    end

    // reduce by x^128 + x^7 + x^2 + x + 1, two folds
    assign upper = prod[2*BLOCK_W-2:BLOCK_W];
    assign fold1 = {6'b0, prod[BLOCK_W-1:0]}
                 ^ {7'b0, upper}
                 ^ {6'b0, upper, 1'b0}
                 ^ {5'b0, upper, 2'b0}
                 ^ {upper, 7'b0};
    assign spill = fold1[BLOCK_W+5:BLOCK_W];
    assign r     = fold1[BLOCK_W-1:0]
                 ^ {{(BLOCK_W-6){1'b0}}, spill}
                 ^ {{(BLOCK_W-7){1'b0}}, spill, 1'b0}
                 ^ {{(BLOCK_W-8){1'b0}}, spill, 2'b0}
                 ^ {{(BLOCK_W-13){1'b0}}, spill, 7'b0};

    always_comb begin
        for (int i = 0; i < BLOCK_W; i++) begin
            z_out[BLOCK_W-1-i] = r[i];
        end
    end

endmodule

// File: design/gcm_ghash_authenticator.sv
// top level of the ghash authenticator: input stage, hash state and tag register
//
// ghash authenticator: takes 128-bit blocks of additional data (kind 0), then
// of text or iv (kind 1), each with a count of leading valid bytes (the rest
// is forced to zero, counts above 16 count as 16, a count of zero drops the
// beat). every block is xored into the hash y, which is then multiplied by the
// hash key h in gf(2^128) with the standard ghash bit order. a finish beat
// (kind 2) folds in the 64-bit bit lengths of both sections, delivers y as the
// tag and clears the hash and byte counts; kind 3 is dropped. one beat is
// accepted every cycle: a beat is masked into an input register, and the next
// cycle one pass through the combinational field multiplier updates y; a finish
// beat goes from the input register to the output tag register. data beats keep
// flowing while the tag waits, and only a second finish beat waits for it to be
// taken. h is written through the apb port (high half at 0x0, low half at 0x8)
// by the user only while the block is idle; the block does not enforce this.
module gcm_ghash_authenticator
    import gh_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input beats
    input  logic               s_valid,
    output logic               s_ready,
    input  gh_in_t             s_data,
    // tag beats
    output logic               m_valid,
    input  logic               m_ready,
    output gh_out_t            m_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // hash key registers
    logic [HALF_W-1:0] key_high_reg, key_high_next;
    logic [HALF_W-1:0] key_low_reg,  key_low_next;

    // input stage: masked block and decoded kind
    logic                s1_valid_reg,  s1_valid_next;
    logic                s1_finish_reg, s1_finish_next;
    logic                s1_aad_reg,    s1_aad_next;
    logic [NBYTES_W-1:0] s1_count_reg,  s1_count_next;
    logic [BLOCK_W-1:0]  s1_block_reg,  s1_block_next;

    // hash state and section byte counts
    logic [BLOCK_W-1:0] y_reg,        y_next;
    logic [COUNT_W-1:0] aad_cnt_reg,  aad_cnt_next;
    logic [COUNT_W-1:0] text_cnt_reg, text_cnt_next;

    // tag output register
    logic               m_valid_reg, m_valid_next;
    logic [BLOCK_W-1:0] tag_reg,     tag_next;

    logic               s_fire;
    logic               s1_fire;
    logic               cfg_write;
    logic [NBYTES_W-1:0] nbytes;
    logic [BLOCK_W-1:0] raw_block;
    logic [BLOCK_W-1:0] masked_block;
    logic [BLOCK_W-1:0] mul_x;
    logic [BLOCK_W-1:0] mul_z;
    logic               kind_is_data;

    // apb: no wait states, register picked by one address bit
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[REG_SEL_BIT] == REG_KEY_LOW) ? key_low_reg : key_high_reg;

    always_comb begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (cfg_write) begin
            if (paddr[REG_SEL_BIT] == REG_KEY_LOW) begin
                key_low_next = pwdata;
            end else begin
                key_high_next = pwdata;
            end
        end
    end

    // a finish beat needs the tag register free; data beats always go
    assign s1_fire = s1_valid_reg && (!s1_finish_reg || !m_valid_reg || m_ready);
    // input stage frees up whenever its content moves on
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    // clamp the byte count to a full block
    assign nbytes       = s_data.valid_bytes[NBYTES_W-1] ?
                          NBYTES_W'(BLOCK_BYTES) : s_data.valid_bytes;
    assign raw_block    = {s_data.data_high, s_data.data_low};
    assign kind_is_data = (s_data.kind == KIND_AAD) || (s_data.kind == KIND_TEXT);

    // zero the bytes past the valid count, byte 0 in the top bits
    always_comb begin
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            if (NBYTES_W'(b) < nbytes) begin
                masked_block[BLOCK_W-1-8*b -: 8] = raw_block[BLOCK_W-1-8*b -: 8];
            end else begin
                masked_block[BLOCK_W-1-8*b -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_finish_next = s1_finish_reg;
        s1_aad_next    = s1_aad_reg;
        s1_count_next  = s1_count_reg;
        s1_block_next  = s1_block_reg;
        if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
        if (s_fire) begin
            // kind 3 and empty data beats are taken and dropped here
            s1_valid_next  = (s_data.kind == KIND_FINISH) ||
                             (kind_is_data && (s_data.valid_bytes != '0));
            s1_finish_next = (s_data.kind == KIND_FINISH);
            s1_aad_next    = (s_data.kind == KIND_AAD);
            s1_count_next  = nbytes;
            s1_block_next  = masked_block;
        end
    end

    // on finish the length block is aad bits in the top half, text bits below
    assign mul_x = y_reg ^ (s1_finish_reg ?
                            {aad_cnt_reg, 3'b000, text_cnt_reg, 3'b000} : s1_block_reg);

    gh_gfmul u_gh_gfmul (
        .x_in  (mul_x),
        .h_in  ({key_high_reg, key_low_reg}),
        .z_out (mul_z)
    );

    always_comb begin
        y_next        = y_reg;
        aad_cnt_next  = aad_cnt_reg;
        text_cnt_next = text_cnt_reg;
        tag_next      = tag_reg;
        m_valid_next  = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s1_fire) begin
            if (s1_finish_reg) begin
                tag_next      = mul_z;
                m_valid_next  = 1'b1;
                y_next        = '0;
                aad_cnt_next  = '0;
                text_cnt_next = '0;
            end else begin
                y_next = mul_z;
                // counts wrap at 2^61
                if (s1_aad_reg) begin
                    aad_cnt_next = aad_cnt_reg + COUNT_W'(s1_count_reg);
                end else begin
                    text_cnt_next = text_cnt_reg + COUNT_W'(s1_count_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            y_reg         <= '0;
            aad_cnt_reg   <= '0;
            text_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            key_high_reg  <= key_high_next;
            key_low_reg   <= key_low_next;
            s1_valid_reg  <= s1_valid_next;
            y_reg         <= y_next;
            aad_cnt_reg   <= aad_cnt_next;
            text_cnt_reg  <= text_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        s1_finish_reg <= s1_finish_next;
        s1_aad_reg    <= s1_aad_next;
        s1_count_reg  <= s1_count_next;
        s1_block_reg  <= s1_block_next;
        tag_reg       <= tag_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_data.tag_high = tag_reg[BLOCK_W-1:HALF_W];
    assign m_data.tag_low  = tag_reg[HALF_W-1:0];

endmodule

// File: design/gh_checker.sv
// port-level checks of the ghash authenticator, bound to the top level
module gh_checker
    import gh_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input gh_in_t  s_data,
    input logic    m_valid,
    input logic    m_ready,
    input gh_out_t m_data
);

    // a waiting input beat stays up and keeps its payload
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed before it was taken");

    // a waiting tag beat stays up
    a_tag_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("tag beat dropped before it was taken");

    // a waiting tag beat keeps its value
    a_tag_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("tag changed while waiting");

    // with the tag register free the input never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no tag pending");

    // reset leaves no tag pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("tag beat pending after reset");

endmodule

bind gcm_ghash_authenticator gh_checker u_gh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
